@@ src/png_scanline_unfilter_top_macros.svh @@
// Assertion macros for the PNG scanline unfilter.
`ifndef PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PNG_UNF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PNG_UNF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/png_unf_pkg.sv @@
// Package for the PNG scanline unfilter: constants, codes and Paeth predictor.
package png_unf_pkg;

  localparam int unsigned MAX_ROW_BYTES   = 8192;
  localparam int unsigned MAX_PIXEL_BYTES = 8;
  localparam int unsigned CFG_DATA_W      = 14;
  localparam int unsigned CFG_IDX_W       = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_ROW_BYTES       = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic [1:0] {
    OP_FILT = 2'd0,
    OP_DATA = 2'd1,
    OP_ERR  = 2'd2
  } op_e;

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] pa;
    logic [7:0] pb;
    logic [9:0] s;
    logic [9:0] t;
    logic [9:0] pc;
    logic [7:0] res;
    pa = (b > c) ? (b - c) : (c - b);
    pb = (a > c) ? (a - c) : (c - a);
    s  = {2'b00, a} + {2'b00, b};
    t  = {1'b0, c, 1'b0};
    pc = (s > t) ? (s - t) : (t - s);
    if (pa <= pb && {2'b00, pa} <= pc) begin
      res = a;
    end else if ({2'b00, pb} <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

@@ src/png_unf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
module png_unf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/png_scanline_unfilter_top.sv @@
// PNG scanline unfilter: row framing, line store and byte reconstruction.
//
// Input channel (in_valid_i / in_stall_o) takes the inflated image stream,
// one byte per beat. The first byte of each row is the filter type, then
// row_bytes filtered data bytes follow. new_image_i marks the first byte of
// an image. Output channel (out_valid_o / out_stall_i) gives one beat per
// data byte with the reconstructed value, row_last_o on the row's last byte.
// A filter type above 4 gives one beat with bad_filter_o set, then all
// bytes are dropped until new_image_i. Filter type bytes give no beat.
// Throughput is one byte per cycle while the receiver does not stall, set by the
// single add plus Paeth compare in the reconstruction stage; the line store
// read is issued when the byte is accepted so its registered data is ready in
// that stage. An accepted byte is registered in the reconstruction stage,
// then in the output register.
// The user must write the configuration port only while the block is idle;
// the block does not enforce this. Reset clears the framing state and
// histories; the line store needs no clearing since the first row of an
// image never uses its data. When the receiver stalls, the output register
// holds and in_stall_o rises once the reconstruction stage is also full.
module png_scanline_unfilter_top #(
  parameter int unsigned MaxRowBytes   = png_unf_pkg::MAX_ROW_BYTES,
  parameter int unsigned MaxPixelBytes = png_unf_pkg::MAX_PIXEL_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [png_unf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [png_unf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               new_image_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         recon_byte_o,
  output logic                               row_last_o,
  output logic                               bad_filter_o
);

  `include "png_scanline_unfilter_top_macros.svh"

  localparam int unsigned IdxW = (MaxRowBytes > 1) ? $clog2(MaxRowBytes) : 1;
  localparam int unsigned LenW = $clog2(MaxRowBytes + 1);
  localparam int unsigned PixW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

  // configuration
  logic [PixW-1:0] bpp_sel_q, bpp_sel_d;
  logic [LenW-1:0] len_q, len_d;
  logic [3:0]      cfg_bpp;
  logic [31:0]     cfg_len;

  always_comb begin
    bpp_sel_d = bpp_sel_q;
    len_d     = len_q;
    cfg_bpp   = cfg_data_i[3:0];
    cfg_len   = 32'(cfg_data_i);
    if (cfg_we_i) begin
      unique case (png_unf_pkg::reg_idx_e'(cfg_idx_i))
        png_unf_pkg::REG_BYTES_PER_PIXEL: begin
          if (cfg_bpp == 4'd0) begin
            bpp_sel_d = '0;
          end else if (32'(cfg_bpp) > MaxPixelBytes) begin
            bpp_sel_d = PixW'(MaxPixelBytes - 1);
          end else begin
            bpp_sel_d = PixW'(cfg_bpp - 4'd1);
          end
        end
        png_unf_pkg::REG_ROW_BYTES: begin
          if (cfg_len == 32'd0) begin
            len_d = LenW'(1);
          end else if (cfg_len > MaxRowBytes) begin
            len_d = LenW'(MaxRowBytes);
          end else begin
            len_d = LenW'(cfg_len);
          end
        end
        default: ;
      endcase
    end
  end

  // front end: row framing at accept time
  logic              pos_eff_zero;
  logic [LenW-1:0]   pos_q, pos_d, pos_eff;
  logic              first_q, first_d, first_eff;
  logic              halted_q, halted_d, halt_eff;
  png_unf_pkg::filt_e filter_q, filter_d;
  logic              in_accept;
  logic              is_data;
  logic              front_last;
  logic              s1_load;
  png_unf_pkg::op_e  front_op;
  logic [IdxW-1:0]   front_idx;

  // stage 1
  logic              s1_valid_q, s1_valid_d;
  png_unf_pkg::op_e  s1_op_q;
  logic [7:0]        s1_x_q;
  png_unf_pkg::filt_e s1_filter_q;
  logic              s1_first_q;
  logic              s1_last_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s1_go;
  logic              out_free;

  assign pos_eff      = new_image_i ? '0 : pos_q;
  assign first_eff    = new_image_i | first_q;
  assign halt_eff     = ~new_image_i & halted_q;
  assign pos_eff_zero = (pos_eff == '0);
  assign is_data      = ~halt_eff & ~pos_eff_zero;
  assign front_last   = (pos_eff >= len_q);
  assign front_idx    = IdxW'(pos_eff - LenW'(1));

  assign out_free   = ~out_valid_o | ~out_stall_i;
  assign s1_go      = s1_valid_q & ((s1_op_q == png_unf_pkg::OP_FILT) | out_free);
  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign s1_load    = in_accept & ~halt_eff;

  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    halted_d = halted_q;
    filter_d = filter_q;
    front_op = png_unf_pkg::OP_DATA;
    if (halt_eff) begin
      front_op = png_unf_pkg::OP_FILT;
    end else if (pos_eff_zero) begin
      if (data_byte_i > png_unf_pkg::FILT_MAX_CODE) begin
        front_op = png_unf_pkg::OP_ERR;
      end else begin
        front_op = png_unf_pkg::OP_FILT;
      end
    end
    if (in_accept) begin
      pos_d    = pos_eff;
      first_d  = first_eff;
      halted_d = halt_eff;
      if (!halt_eff) begin
        if (pos_eff_zero) begin
          if (front_op == png_unf_pkg::OP_ERR) begin
            halted_d = 1'b1;
          end else begin
            filter_d = png_unf_pkg::filt_e'(data_byte_i[2:0]);
            pos_d    = LenW'(1);
          end
        end else if (front_last) begin
          pos_d   = '0;
          first_d = 1'b0;
        end else begin
          pos_d = pos_eff + LenW'(1);
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      s1_valid_d = s1_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_sel_q  <= '0;
      len_q      <= LenW'(1);
      pos_q      <= '0;
      first_q    <= 1'b1;
      halted_q   <= 1'b0;
      filter_q   <= png_unf_pkg::FILT_NONE;
      s1_valid_q <= 1'b0;
    end else begin
      bpp_sel_q  <= bpp_sel_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      first_q    <= first_d;
      halted_q   <= halted_d;
      filter_q   <= filter_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q     <= front_op;
      s1_x_q      <= data_byte_i;
      s1_filter_q <= filter_q;
      s1_first_q  <= first_eff;
      s1_last_q   <= front_last;
      s1_idx_q    <= front_idx;
    end
  end

  // line store
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  logic [7:0] recon;

  assign ram_we = s1_go & (s1_op_q == png_unf_pkg::OP_DATA);
  assign ram_re = in_accept & is_data;

  png_unf_ram #(
    .Width(8),
    .Depth(MaxRowBytes)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_idx_q),
    .wdata_i(recon),
    .re_i   (ram_re),
    .raddr_i(front_idx),
    .rdata_o(ram_rdata)
  );

  // reconstruction
  logic [7:0] left_q [MaxPixelBytes];
  logic [7:0] upleft_q [MaxPixelBytes];
  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [8:0] avg_sum;
  logic [7:0] pred;

  assign nb_a    = left_q[bpp_sel_q];
  assign nb_c    = upleft_q[bpp_sel_q];
  assign nb_b    = s1_first_q ? 8'd0 : ram_rdata;
  assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

  always_comb begin
    unique case (s1_filter_q)
      png_unf_pkg::FILT_SUB:   pred = nb_a;
      png_unf_pkg::FILT_UP:    pred = nb_b;
      png_unf_pkg::FILT_AVG:   pred = avg_sum[8:1];
      png_unf_pkg::FILT_PAETH: pred = png_unf_pkg::paeth_pick(nb_a, nb_b, nb_c);
      default:                 pred = 8'd0;
    endcase
  end

  assign recon = s1_x_q + pred;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPixelBytes; k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else if (s1_go) begin
      if (s1_op_q == png_unf_pkg::OP_DATA) begin
        left_q[0]   <= recon;
        upleft_q[0] <= nb_b;
        for (int k = 1; k < MaxPixelBytes; k++) begin
          left_q[k]   <= left_q[k-1];
          upleft_q[k] <= upleft_q[k-1];
        end
      end else begin
        for (int k = 0; k < MaxPixelBytes; k++) begin
          left_q[k]   <= 8'd0;
          upleft_q[k] <= 8'd0;
        end
      end
    end
  end

  // output register
  logic       out_load;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_bad_q;

  assign out_load = s1_go & (s1_op_q != png_unf_pkg::OP_FILT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (s1_op_q == png_unf_pkg::OP_ERR) begin
        out_byte_q <= 8'd0;
        out_last_q <= 1'b0;
        out_bad_q  <= 1'b1;
      end else begin
        out_byte_q <= recon;
        out_last_q <= s1_last_q;
        out_bad_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign recon_byte_o = out_byte_q;
  assign row_last_o   = out_last_q;
  assign bad_filter_o = out_bad_q;

  `PNG_UNF_ASSERT(a_err_beat_clean,
      (out_valid_o && bad_filter_o) |-> (recon_byte_o == 8'd0 && !row_last_o),
      "error beat carries data or row end")
  `PNG_UNF_NEVER(a_store_same_addr, ram_we && ram_re && (s1_idx_q == front_idx),
      "line store read and written at the same address")
  `PNG_UNF_ASSERT(a_mid_row_pos,
      (s1_valid_q && s1_op_q == png_unf_pkg::OP_DATA && !s1_last_q) |-> (pos_q != '0),
      "row position cleared before the row's last byte")

endmodule

@@ bench/tb_png_scanline_unfilter_top.sv @@
// Self-checking testbench for png_scanline_unfilter_top: directed table, random images, oversized row.
module tb_png_scanline_unfilter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import png_unf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned ITEM_TARGET = 2000;

  typedef struct packed {
    logic [7:0] recon;
    logic       last;
    logic       bad;
  } outcome_t;

  typedef struct packed {
    bit                    is_cfg;
    reg_idx_e              sel;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            data;
    logic                  img_start;
    bit                    typed;
    outcome_t              want;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  new_image_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            recon_byte_o;
  logic                  row_last_o;
  logic                  bad_filter_o;

  png_scanline_unfilter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .new_image_i  (new_image_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .recon_byte_o (recon_byte_o),
    .row_last_o   (row_last_o),
    .bad_filter_o (bad_filter_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state
  logic [3:0]            pix_bytes = 4'd1;
  logic [CFG_DATA_W-1:0] row_len = 14'd1;
  logic [7:0]            line_mem [MAX_ROW_BYTES];
  logic [63:0]           left_hist = '0;
  logic [63:0]           upleft_hist = '0;
  int unsigned           row_pos = 0;
  filt_e                 cur_filt = FILT_NONE;
  bit                    first_row = 1'b1;
  bit                    halted_img = 1'b0;

  outcome_t    recon_q[$];
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_taken = 0;
  bit          calm = 1'b0;
  int unsigned stall_run = 0;

  function automatic logic [7:0] paeth_select(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Returns 1 when the byte yields an output beat.
  function automatic bit unfilter_step(input logic [7:0] x, input logic img_start,
                                       output outcome_t res);
    int unsigned bpp;
    int unsigned len;
    int unsigned idx;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  r;
    logic [8:0]  avg_sum;
    res = '0;
    if (img_start) begin
      halted_img = 1'b0;
      first_row  = 1'b1;
      row_pos    = 0;
    end
    if (halted_img) return 1'b0;
    if (row_pos == 0) begin
      left_hist   = '0;
      upleft_hist = '0;
      if (x > FILT_MAX_CODE) begin
        halted_img = 1'b1;
        res.bad    = 1'b1;
        return 1'b1;
      end
      cur_filt = filt_e'(x[2:0]);
      row_pos  = 1;
      return 1'b0;
    end
    bpp = (pix_bytes == 0) ? 1 : (pix_bytes > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : pix_bytes;
    len = (row_len == 0) ? 1 : (row_len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_len;
    idx = row_pos - 1;
    if (idx >= MAX_ROW_BYTES) idx = MAX_ROW_BYTES - 1;
    a = left_hist[(bpp-1)*8 +: 8];
    c = upleft_hist[(bpp-1)*8 +: 8];
    b = first_row ? 8'd0 : line_mem[idx];
    avg_sum = {1'b0, a} + {1'b0, b};
    case (cur_filt)
      FILT_SUB:   r = x + a;
      FILT_UP:    r = x + b;
      FILT_AVG:   r = x + avg_sum[8:1];
      FILT_PAETH: r = x + paeth_select(a, b, c);
      default:    r = x;
    endcase
    line_mem[idx] = r;
    left_hist     = {left_hist[55:0], r};
    upleft_hist   = {upleft_hist[55:0], b};
    res.recon     = r;
    res.last      = (idx + 1 >= len);
    if (res.last) begin
      row_pos   = 0;
      first_row = 1'b0;
    end else begin
      row_pos = idx + 2;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] data_pick();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (recon_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e sel, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == REG_BYTES_PER_PIXEL) pix_bytes = val[3:0];
    else row_len = val;
  endtask

  task automatic send_byte(input logic [7:0] d, input logic img_start, input bit typed,
                           input outcome_t want);
    int unsigned gap;
    outcome_t    res;
    gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : idle_len());
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    new_image_i <= img_start;
    do @(posedge clk_i); while (in_stall_o);
    if (img_start || !halted_img) items_taken++;
    if (unfilter_step(d, img_start, res)) recon_q.push_back(typed ? want : res);
  endtask

  // One row: filter byte, then data until the row closes, the image halts or noise breaks it off.
  task automatic send_row(input logic img_start, input bit noisy, output bit broken);
    logic [7:0]  f;
    int unsigned r;
    broken = 1'b0;
    if (noisy && $urandom_range(0, 19) == 0) f = 8'($urandom_range(FILT_MAX_CODE + 1, 255));
    else f = 8'($urandom_range(0, FILT_MAX_CODE));
    send_byte(f, img_start, 1'b0, '0);
    while (row_pos != 0 && !halted_img) begin
      r = noisy ? $urandom_range(0, 99) : 99;
      if (r == 0) begin
        broken = 1'b1;
        return;
      end
      if (r == 1) write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(0, 15)));
      else if (r == 2 && row_len > 1)
        write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(1, row_len - 1)));
      send_byte(data_pick(), 1'b0, 1'b0, '0);
    end
  endtask

  task automatic run_image();
    int unsigned rows;
    int unsigned k;
    int unsigned r;
    bit          broken;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) drain_results();
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(0, 15)));
    // row length may only grow at an image start
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(1, 8)));
      else if (r < 95) write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(9, 40)));
      else write_reg(REG_ROW_BYTES, CFG_DATA_W'($urandom_range(41, 200)));
    end
    rows = $urandom_range(1, 6);
    for (k = 0; k < rows; k++) begin
      send_row(k == 0, 1'b1, broken);
      if (halted_img) begin
        repeat ($urandom_range(0, 4)) send_byte(data_pick(), 1'b0, 1'b0, '0);
        break;
      end
      if (broken) break;
    end
  endtask

  function automatic step_t plan_byte(input logic [7:0] d, input logic img_start);
    step_t s;
    s = '0;
    s.data = d;
    s.img_start = img_start;
    return s;
  endfunction

  function automatic step_t plan_checked(input logic [7:0] d, input logic img_start,
                                         input logic [7:0] recon, input logic last,
                                         input logic bad);
    step_t s;
    s = plan_byte(d, img_start);
    s.typed = 1'b1;
    s.want  = '{recon: recon, last: last, bad: bad};
    return s;
  endfunction

  function automatic step_t plan_reg(input reg_idx_e sel, input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.sel    = sel;
    s.value  = val;
    return s;
  endfunction

  // Output side: random stalls, checking.
  always @(posedge clk_i) begin
    outcome_t seen;
    outcome_t want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= idle_len();
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {recon_byte_o, row_last_o, bad_filter_o};
      if (recon_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected beat: recon %02h last %0b bad %0b",
                   seen.recon, seen.last, seen.bad);
      end else begin
        want = recon_q.pop_front();
        if (seen.recon !== want.recon || seen.last !== want.last || seen.bad !== want.bad) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: recon %02h/%02h last %0b/%0b bad %0b/%0b (exp/act)",
                     want.recon, seen.recon, want.last, seen.last, want.bad, seen.bad);
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    step_t plan[$];
    plan.push_back(plan_byte(8'(FILT_NONE), 1'b1));
    plan.push_back(plan_checked(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0));
    plan.push_back(plan_reg(REG_BYTES_PER_PIXEL, 14'd0));
    plan.push_back(plan_reg(REG_ROW_BYTES, 14'd0));
    plan.push_back(plan_byte(8'(FILT_SUB), 1'b0));
    plan.push_back(plan_checked(8'h80, 1'b0, 8'h80, 1'b1, 1'b0));
    plan.push_back(plan_reg(REG_BYTES_PER_PIXEL, 14'd15));
    plan.push_back(plan_reg(REG_ROW_BYTES, 14'd3));
    plan.push_back(plan_byte(8'(FILT_PAETH), 1'b1));
    plan.push_back(plan_byte(8'h00, 1'b0));
    plan.push_back(plan_byte(8'h7F, 1'b0));
    plan.push_back(plan_byte(8'hFF, 1'b0));
    plan.push_back(plan_byte(8'(FILT_AVG), 1'b0));
    plan.push_back(plan_byte(8'h10, 1'b0));
    plan.push_back(plan_byte(8'h20, 1'b0));
    plan.push_back(plan_byte(8'h30, 1'b0));
    plan.push_back(plan_reg(REG_BYTES_PER_PIXEL, 14'd2));
    plan.push_back(plan_byte(8'(FILT_PAETH), 1'b0));
    plan.push_back(plan_byte(8'h9C, 1'b0));
    plan.push_back(plan_byte(8'h01, 1'b0));
    plan.push_back(plan_byte(8'hE5, 1'b0));
    // bad filter, then bytes dropped until the next image
    plan.push_back(plan_checked(8'h05, 1'b0, 8'h00, 1'b0, 1'b1));
    plan.push_back(plan_byte(8'h33, 1'b0));
    plan.push_back(plan_byte(8'hFF, 1'b0));
    plan.push_back(plan_checked(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1));
    // row length cut mid-row
    plan.push_back(plan_byte(8'(FILT_NONE), 1'b1));
    plan.push_back(plan_byte(8'h55, 1'b0));
    plan.push_back(plan_reg(REG_ROW_BYTES, 14'd1));
    plan.push_back(plan_checked(8'hAA, 1'b0, 8'hAA, 1'b1, 1'b0));
    plan.push_back(plan_byte(8'(FILT_UP), 1'b0));
    plan.push_back(plan_byte(8'h01, 1'b0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) write_reg(plan[n].sel, plan[n].value);
      else send_byte(plan[n].data, plan[n].img_start, plan[n].typed, plan[n].want);
    end

    items_taken = 0;
    while (items_taken < ITEM_TARGET) run_image();

    // row length above the maximum acts as the maximum: no row end here
    calm = 1'b0;
    write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'($urandom_range(1, MAX_PIXEL_BYTES)));
    write_reg(REG_ROW_BYTES, '1);
    send_byte(8'(FILT_SUB), 1'b1, 1'b0, '0);
    repeat (40) send_byte(data_pick(), 1'b0, 1'b0, '0);

    drain_results();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ png_scanline_unfilter_top.f @@
+incdir+src
src/png_unf_pkg.sv
src/png_unf_ram.sv
src/png_scanline_unfilter_top.sv
bench/tb_png_scanline_unfilter_top.sv
